// ===== hdl/vfra_pkg.sv =====
// package: widths, beat types, codes and helpers for the frame ring admission core
`timescale 1ns / 1ps

package vfra_pkg;

  localparam int RING_DEPTH = 64;
  localparam int POS_W      = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int WIDE_W     = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int HANDLE_W   = 16;
  localparam int LENGTH_W   = 20;
  localparam int RUN_W      = 16;
  localparam int OUTCOME_W  = 3;
  localparam int CLASS_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_RESERVE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EARLY_RESERVE = 2'd2;

  localparam logic [CFG_W-1:0] SLOT_COUNT_RESET    = 7'd64;
  localparam logic [CFG_W-1:0] FULL_RESERVE_RESET  = 7'd20;
  localparam logic [CFG_W-1:0] EARLY_RESERVE_RESET = 7'd30;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_TAKE = 1'b1;

  localparam logic [CLASS_W-1:0] CLASS_PREVIEW = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_KEY     = 2'd2;

  localparam logic [OUTCOME_W-1:0] OC_STORED    = 3'd0;
  localparam logic [OUTCOME_W-1:0] OC_LOST      = 3'd1;
  localparam logic [OUTCOME_W-1:0] OC_AWAIT     = 3'd2;
  localparam logic [OUTCOME_W-1:0] OC_PICTURE   = 3'd3;
  localparam logic [OUTCOME_W-1:0] OC_TAKEN     = 3'd4;
  localparam logic [OUTCOME_W-1:0] OC_TAKEN_PIC = 3'd5;
  localparam logic [OUTCOME_W-1:0] OC_EMPTY     = 3'd6;

  typedef struct packed {
    logic                command;
    logic [CLASS_W-1:0]  frame_class;
    logic [HANDLE_W-1:0] frame_handle;
    logic [LENGTH_W-1:0] frame_length;
  } in_beat_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic                 full_warning;
    logic [HANDLE_W-1:0]  out_handle;
    logic [LENGTH_W-1:0]  out_length;
    logic [CNT_W-1:0]     fill_level;
  } out_beat_t;

  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos,
                                                input logic [CNT_W-1:0] slots);
    logic [CNT_W-1:0] n;
    n = CNT_W'(pos) + CNT_W'(1);
    return (n >= slots) ? '0 : n[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/video_frame_ring_admission_core.sv =====
// frame descriptor ring with keyframe gating, picture side slot and near-full warning
// an accepted beat is registered in the result stage, then in the output beat register
// one beat per cycle while out_ready holds; slot store: one write, one registered read port
// state is updated at the accepting edge, so the next beat sees it at once
// reset: synchronous, active high; clears control state, slot flags and registers to defaults
// slot handle and length storage is not cleared and is only read after a write
`timescale 1ns / 1ps

module video_frame_ring_admission_core import vfra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] slot_count;
  logic [CFG_W-1:0] full_reserve;
  logic [CFG_W-1:0] early_reserve;

  logic [RING_DEPTH-1:0] slot_full, slot_full_next;
  logic [HANDLE_W+LENGTH_W-1:0] slot_mem [RING_DEPTH];
  logic [HANDLE_W+LENGTH_W-1:0] rd_data;

  logic [POS_W-1:0]    write_pos, write_pos_next;
  logic [POS_W-1:0]    read_pos, read_pos_next;
  logic [CNT_W-1:0]    held_count, held_count_next;
  logic [RUN_W-1:0]    dropped_run, dropped_run_next;
  logic                await_keyframe, await_keyframe_next;
  logic                first_put_done, first_put_done_next;
  logic                picture_pending, picture_pending_next;
  logic [HANDLE_W-1:0] picture_handle;
  logic [LENGTH_W-1:0] picture_length;

  logic                 a_valid;
  logic [OUTCOME_W-1:0] a_outcome, a_outcome_next;
  logic                 a_warn, a_warn_next;
  logic [CNT_W-1:0]     a_fill;
  logic [HANDLE_W-1:0]  a_pic_handle;
  logic [LENGTH_W-1:0]  a_pic_length;

  logic accept, a_advance, store, take_pic, set_pic;
  logic [WIDE_W-1:0] slots_w, sc_w;
  logic [CNT_W-1:0]  slots;
  logic signed [WIDE_W:0] diff, thr;
  logic is_key;
  logic [RUN_W-1:0] run_eff;

  assign accept    = in_valid && in_ready;
  assign a_advance = a_valid && (!out_valid || out_ready);
  assign in_ready  = !a_valid || a_advance;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= SLOT_COUNT_RESET;
      full_reserve  <= FULL_RESERVE_RESET;
      early_reserve <= EARLY_RESERVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SLOT_COUNT:    slot_count    <= cfg_data;
        REG_FULL_RESERVE:  full_reserve  <= cfg_data;
        REG_EARLY_RESERVE: early_reserve <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sc_w = WIDE_W'(slot_count);
    if (slot_count == '0) begin
      slots_w = WIDE_W'(1);
    end else if (sc_w > WIDE_W'(RING_DEPTH)) begin
      slots_w = WIDE_W'(RING_DEPTH);
    end else begin
      slots_w = sc_w;
    end
    slots = slots_w[CNT_W-1:0];
    diff  = $signed({1'b0, slots_w}) - $signed({1'b0, WIDE_W'(early_reserve)});
    thr   = (diff + $signed({{WIDE_W{1'b0}}, diff[WIDE_W]})) >>> 1;
    is_key = (in_data.frame_class == CLASS_KEY);
    run_eff = (dropped_run != '0 && is_key) ? '0 : dropped_run;
  end

  always_comb begin
    slot_full_next       = slot_full;
    write_pos_next       = write_pos;
    read_pos_next        = read_pos;
    held_count_next      = held_count;
    dropped_run_next     = dropped_run;
    await_keyframe_next  = await_keyframe;
    first_put_done_next  = first_put_done;
    picture_pending_next = picture_pending;
    a_outcome_next       = OC_EMPTY;
    a_warn_next          = 1'b0;
    store                = 1'b0;
    take_pic             = 1'b0;
    set_pic              = 1'b0;
    if (in_data.command == CMD_PUT) begin
      if (!first_put_done) begin
        if ($signed({1'b0, WIDE_W'(held_count)}) >= thr) begin
          a_warn_next = 1'b1;
        end
        first_put_done_next = 1'b1;
      end
      if (WIDE_W'(held_count) + WIDE_W'(full_reserve) >= slots_w) begin
        a_warn_next = 1'b1;
      end
      if (!picture_pending && in_data.frame_class == CLASS_PREVIEW) begin
        set_pic              = 1'b1;
        picture_pending_next = 1'b1;
        a_outcome_next       = OC_PICTURE;
      end else begin
        dropped_run_next = run_eff;
        if (slot_full[write_pos] || run_eff != '0) begin
          if (run_eff != '1) begin
            dropped_run_next = run_eff + RUN_W'(1);
          end
          a_outcome_next = OC_LOST;
        end else if (await_keyframe && !is_key) begin
          a_outcome_next = OC_AWAIT;
        end else begin
          store                     = 1'b1;
          await_keyframe_next       = 1'b0;
          slot_full_next[write_pos] = 1'b1;
          write_pos_next            = next_pos(write_pos, slots);
          if (held_count < CNT_W'(RING_DEPTH)) begin
            held_count_next = held_count + CNT_W'(1);
          end
          a_outcome_next = OC_STORED;
        end
      end
    end else begin
      if (picture_pending) begin
        take_pic             = 1'b1;
        picture_pending_next = 1'b0;
        a_outcome_next       = OC_TAKEN_PIC;
      end else if (slot_full[read_pos]) begin
        slot_full_next[read_pos] = 1'b0;
        read_pos_next            = next_pos(read_pos, slots);
        if (held_count != '0) begin
          held_count_next = held_count - CNT_W'(1);
        end
        a_outcome_next = OC_TAKEN;
      end
    end
  end

  // ring state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full       <= '0;
      write_pos       <= '0;
      read_pos        <= '0;
      held_count      <= '0;
      dropped_run     <= '0;
      await_keyframe  <= 1'b1;
      first_put_done  <= 1'b0;
      picture_pending <= 1'b0;
      picture_handle  <= '0;
      picture_length  <= '0;
    end else if (accept) begin
      slot_full       <= slot_full_next;
      write_pos       <= write_pos_next;
      read_pos        <= read_pos_next;
      held_count      <= held_count_next;
      dropped_run     <= dropped_run_next;
      await_keyframe  <= await_keyframe_next;
      first_put_done  <= first_put_done_next;
      picture_pending <= picture_pending_next;
      if (set_pic) begin
        picture_handle <= in_data.frame_handle;
        picture_length <= in_data.frame_length;
      end
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (accept && store) begin
      slot_mem[write_pos] <= {in_data.frame_handle, in_data.frame_length};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= slot_mem[read_pos];
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_outcome <= a_outcome_next;
      a_warn    <= a_warn_next;
      a_fill    <= held_count_next;
      if (take_pic) begin
        a_pic_handle <= picture_handle;
        a_pic_length <= picture_length;
      end
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_data.outcome      <= a_outcome;
      out_data.full_warning <= a_warn;
      out_data.fill_level   <= a_fill;
      case (a_outcome)
        OC_TAKEN: begin
          out_data.out_handle <= rd_data[HANDLE_W+LENGTH_W-1:LENGTH_W];
          out_data.out_length <= rd_data[LENGTH_W-1:0];
        end
        OC_TAKEN_PIC: begin
          out_data.out_handle <= a_pic_handle;
          out_data.out_length <= a_pic_length;
        end
        default: begin
          out_data.out_handle <= '0;
          out_data.out_length <= '0;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_held_matches_flags: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(slot_full)) == held_count)
    else $error("held count differs from occupied slots");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CNT_W'(RING_DEPTH))
    else $error("held count above ring depth");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (a_valid && out_valid && !out_ready) |=> (a_valid && $stable(a_outcome)))
    else $error("result stage lost a beat under stall");

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.command == CMD_TAKE && !picture_pending && slot_full[read_pos])
      |=> !slot_full[$past(read_pos)])
    else $error("taken slot still marked full");
`endif

endmodule
